/* rtl/core/lom_pkg.sv */
// lom_pkg: shared types and codes for the limit order matcher
// no dependencies; imported by limit_order_matcher
`default_nettype none
package lom_pkg;
  // result kinds carried on tuser
  typedef logic [2:0] kind_t;
  localparam kind_t KIND_TRADE   = 3'd0;
  localparam kind_t KIND_RESTED  = 3'd1;
  localparam kind_t KIND_FILLED  = 3'd2;
  localparam kind_t KIND_REJECT  = 3'd3;
  localparam kind_t KIND_DROPPED = 3'd4;

  localparam int IN_BYTES  = 12;
  localparam int OUT_BYTES = 17;
endpackage
`default_nettype wire

/* rtl/core/limit_order_matcher.sv */
// limit_order_matcher: price-then-arrival order matching against a slot store
// depends on lom_pkg
`default_nettype none
// usage
//   input channel s_axis: one limit order per item (see tdata field list)
//   output channel m_axis: trade items, then one status item with tlast high
//   kind of each output item on m_axis_tuser
// timing
//   a sequencer walks the slot store one slot per cycle through a single
//   compare/subtract unit; each fill costs two walks (best price level, then
//   oldest order at that level), each skipped level one pair more, and
//   a remainder that rests then searches the store for the lowest free slot
//   a zero quantity order is rejected without a walk
//   s_axis_tready is high only while the block waits for an order
// reset
//   rst empties the book and clears the arrival counter; slot contents
//   are not cleared, the per-slot valid bits guard them
// stalls
//   every output item sits in a register until m_axis_tready takes it;
//   the sequencer holds while it waits
module limit_order_matcher
  import lom_pkg::*;
#(
  parameter int ORDER_SLOTS = 32,
  parameter int PRICE_BITS  = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // side[0], price[16:1], quantity[40:17], symbol[56:41], order_id[88:57]
  input  wire logic [IN_BYTES*8-1:0]    s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // incoming_id[31:0], resting_id[63:32], trade_price[79:64],
  // trade_quantity[103:80], remaining_quantity[127:104], resting_count[133:128]
  output logic [OUT_BYTES*8-1:0]        m_axis_tdata,
  // kind[2:0]
  output logic [2:0]                    m_axis_tuser,
  output logic                          m_axis_tlast
);
  localparam int IW = $clog2(ORDER_SLOTS);
  localparam int PW = PRICE_BITS;
  localparam logic [IW-1:0] LAST_IDX = IW'(ORDER_SLOTS - 1);
  localparam logic [5:0] FULL_CNT = 6'(ORDER_SLOTS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BEST = 3'd1;
  localparam logic [2:0] S_OLD  = 3'd2;
  localparam logic [2:0] S_FILL = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam logic [2:0] S_FREE = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state;

  // slot store
  logic [ORDER_SLOTS-1:0] slot_valid;
  logic                   slot_side    [ORDER_SLOTS];
  logic [PW-1:0]          slot_price   [ORDER_SLOTS];
  logic [15:0]            slot_symbol  [ORDER_SLOTS];
  logic [31:0]            slot_ident   [ORDER_SLOTS];
  logic [23:0]            slot_units   [ORDER_SLOTS];
  logic [31:0]            slot_arrival [ORDER_SLOTS];
  logic [31:0]            arrival_counter;
  logic [5:0]             count;

  // current order
  logic        side;
  logic [PW-1:0] price;
  logic [23:0] qty;
  logic [15:0] symbol;
  logic [31:0] order_id;

  // scan state
  logic [IW-1:0] idx;
  logic          found;
  logic [PW-1:0] best;
  logic          have_bound;
  logic [PW-1:0] bound;
  logic [IW-1:0] sel;
  logic          sel_found;
  logic [31:0]   sel_age;
  logic [15:0]   sel_sym;
  logic [31:0]   sel_ident;
  logic [23:0]   sel_units;

  // output register
  kind_t       o_kind;
  logic [31:0] o_rest_id;
  logic [15:0] o_price;
  logic [23:0] o_tq;
  logic [23:0] o_rem;
  logic [5:0]  o_count;

  // input unpacking and price masking
  logic [31:0]   in_price_wide;
  logic [PW-1:0] in_price;
  logic [23:0]   in_qty;
  assign in_price_wide = {16'd0, s_axis_tdata[16:1]};
  assign in_price      = in_price_wide[PW-1:0];
  assign in_qty        = s_axis_tdata[40:17];

  // shared slot examine unit: one slot per cycle at idx
  logic          cur_opp;
  logic [PW-1:0] cur_p;
  logic          crosses, beyond, better;
  logic [31:0]   cur_age;
  assign cur_opp = slot_valid[idx] && (slot_side[idx] != side);
  assign cur_p   = slot_price[idx];
  assign crosses = side ? (cur_p >= price) : (cur_p <= price);
  assign beyond  = !have_bound || (side ? (cur_p < bound) : (cur_p > bound));
  assign better  = !found || (side ? (cur_p > best) : (cur_p < best));
  assign cur_age = arrival_counter - slot_arrival[idx];

  logic [23:0] fill;
  assign fill = (sel_units < qty) ? sel_units : qty;

  logic [31:0] best_wide;
  assign best_wide = 32'(best);

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      slot_valid      <= '0;
      arrival_counter <= '0;
      count           <= '0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            side       <= s_axis_tdata[0];
            price      <= in_price;
            qty        <= in_qty;
            symbol     <= s_axis_tdata[56:41];
            order_id   <= s_axis_tdata[88:57];
            have_bound <= 1'b0;
            idx        <= '0;
            found      <= 1'b0;
            if (in_qty == '0) begin
              o_kind        <= KIND_REJECT;
              o_rest_id     <= '0;
              o_price       <= '0;
              o_tq          <= '0;
              o_rem         <= '0;
              o_count       <= count;
              m_axis_tlast  <= 1'b1;
              m_axis_tvalid <= 1'b1;
              state         <= S_OUT;
            end else begin
              state <= S_BEST;
            end
          end
        end
        S_BEST: begin
          if (cur_opp && crosses && beyond && better) begin
            best  <= cur_p;
            found <= 1'b1;
          end
          if (idx == LAST_IDX) begin
            idx       <= '0;
            sel_found <= 1'b0;
            if (found || (cur_opp && crosses && beyond)) state <= S_OLD;
            else                                         state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_OLD: begin
          if (cur_opp && (cur_p == best) && (!sel_found || cur_age > sel_age)) begin
            sel       <= idx;
            sel_found <= 1'b1;
            sel_age   <= cur_age;
            sel_sym   <= slot_symbol[idx];
            sel_ident <= slot_ident[idx];
            sel_units <= slot_units[idx];
          end
          if (idx == LAST_IDX) state <= S_FILL;
          else                 idx   <= idx + 1'b1;
        end
        S_FILL: begin
          if (sel_sym != symbol) begin
            // oldest order at this level is another instrument: skip level
            have_bound <= 1'b1;
            bound      <= best;
            idx        <= '0;
            found      <= 1'b0;
            state      <= S_BEST;
          end else begin
            qty              <= qty - fill;
            slot_units[sel]  <= sel_units - fill;
            if (sel_units == fill) begin
              slot_valid[sel] <= 1'b0;
              count           <= count - 1'b1;
              o_count         <= count - 1'b1;
            end else begin
              o_count         <= count;
            end
            o_kind        <= KIND_TRADE;
            o_rest_id     <= sel_ident;
            o_price       <= best_wide[15:0];
            o_tq          <= fill;
            o_rem         <= qty - fill;
            m_axis_tlast  <= 1'b0;
            m_axis_tvalid <= 1'b1;
            state         <= S_OUT;
          end
        end
        S_DONE: begin
          o_rest_id <= '0;
          o_price   <= '0;
          o_tq      <= '0;
          o_rem     <= qty;
          o_count   <= count;
          if (qty == '0) begin
            o_kind        <= KIND_FILLED;
            m_axis_tlast  <= 1'b1;
            m_axis_tvalid <= 1'b1;
            state         <= S_OUT;
          end else if (count == FULL_CNT) begin
            o_kind        <= KIND_DROPPED;
            m_axis_tlast  <= 1'b1;
            m_axis_tvalid <= 1'b1;
            state         <= S_OUT;
          end else begin
            idx   <= '0;
            state <= S_FREE;
          end
        end
        S_FREE: begin
          // lowest free slot takes the remainder
          if (!slot_valid[idx]) begin
            slot_valid[idx]   <= 1'b1;
            slot_side[idx]    <= side;
            slot_price[idx]   <= price;
            slot_symbol[idx]  <= symbol;
            slot_ident[idx]   <= order_id;
            slot_units[idx]   <= qty;
            slot_arrival[idx] <= arrival_counter;
            arrival_counter   <= arrival_counter + 1'b1;
            count             <= count + 1'b1;
            o_kind            <= KIND_RESTED;
            o_count           <= count + 1'b1;
            m_axis_tlast      <= 1'b1;
            m_axis_tvalid     <= 1'b1;
            state             <= S_OUT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            idx           <= '0;
            found         <= 1'b0;
            if (m_axis_tlast)   state <= S_IDLE;
            else if (qty == '0) state <= S_DONE;
            else                state <= S_BEST;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tuser = o_kind;
  assign m_axis_tdata = {2'b00, o_count, o_rem, o_tq, o_price, o_rest_id, order_id};

  // resting count tracks the valid bits
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    count == 6'($countones(slot_valid)))
    else $error("resting count out of step with valid bits");

  // an output item is only presented from the output wait state
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (state == S_OUT))
    else $error("output valid outside output state");

  // no new order while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("order accepted with result pending");

  // a trade always moves units
  a_trade_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && o_kind == KIND_TRADE) |-> (o_tq != '0))
    else $error("trade with zero quantity");
endmodule
`default_nettype wire

/* tb/sv/tb_limit_order_matcher.sv */
// tb_limit_order_matcher: self-checking bench for the limit order matcher
// depends on lom_pkg and limit_order_matcher; a book model predicts every output item
`timescale 1ns / 1ps

// one output item as seen on the master side
typedef struct packed {
  logic [2:0]  kind;
  logic [31:0] incoming_id;
  logic [31:0] resting_id;
  logic [15:0] trade_price;
  logic [23:0] trade_quantity;
  logic [23:0] remaining_quantity;
  logic [5:0]  resting_count;
  logic        last;
} fill_t;

// expected output items of the book, checked in order
class book_scoreboard;
  bit          bk_valid[32];
  bit          bk_side[32];
  bit [15:0]   bk_price[32];
  bit [15:0]   bk_symbol[32];
  bit [31:0]   bk_ident[32];
  bit [23:0]   bk_units[32];
  bit [31:0]   bk_arrival[32];
  bit [31:0]   arrivals;
  fill_t       pending[$];
  int          mismatches;

  function int live_count();
    int n;
    n = 0;
    foreach (bk_valid[i]) if (bk_valid[i]) n++;
    return n;
  endfunction

  function void push(logic [2:0] k, logic [31:0] inc, logic [31:0] rid,
                     logic [15:0] tp, logic [23:0] tq, logic [23:0] rem, logic lst);
    fill_t f;
    f.kind = k; f.incoming_id = inc; f.resting_id = rid; f.trade_price = tp;
    f.trade_quantity = tq; f.remaining_quantity = rem;
    f.resting_count = 6'(live_count()); f.last = lst;
    pending.insert(pending.size(), f);
  endfunction

  // note one accepted order and predict its items
  function void note_order(bit side, bit [15:0] price, bit [23:0] qty,
                           bit [15:0] sym, bit [31:0] id);
    bit        buy, bounded, found;
    bit [15:0] bound, best;
    bit [31:0] age, sel_age;
    bit [23:0] fill;
    int        sel;
    buy = (side == 0);
    bounded = 0;
    bound = 0;
    if (qty == 0) begin
      push(lom_pkg::KIND_REJECT, id, '0, '0, '0, '0, 1'b1);
      return;
    end
    while (qty > 0) begin
      found = 0;
      best = 0;
      for (int i = 0; i < 32; i++) begin
        if (!bk_valid[i] || bk_side[i] == side) continue;
        if (buy ? (bk_price[i] > price) : (bk_price[i] < price)) continue;
        if (bounded && (buy ? (bk_price[i] <= bound) : (bk_price[i] >= bound))) continue;
        if (!found || (buy ? (bk_price[i] < best) : (bk_price[i] > best))) begin
          best = bk_price[i];
          found = 1;
        end
      end
      if (!found) break;
      sel = -1;
      sel_age = 0;
      for (int i = 0; i < 32; i++) begin
        if (!bk_valid[i] || bk_side[i] == side || bk_price[i] != best) continue;
        age = arrivals - bk_arrival[i];
        if (sel < 0 || age > sel_age) begin
          sel = i;
          sel_age = age;
        end
      end
      // oldest order at this level has another symbol: skip the level
      if (bk_symbol[sel] != sym) begin
        bounded = 1;
        bound = best;
        continue;
      end
      fill = (bk_units[sel] < qty) ? bk_units[sel] : qty;
      qty -= fill;
      bk_units[sel] -= fill;
      if (bk_units[sel] == 0) bk_valid[sel] = 0;
      push(lom_pkg::KIND_TRADE, id, bk_ident[sel], best, fill, qty, 1'b0);
    end
    if (qty == 0) begin
      push(lom_pkg::KIND_FILLED, id, '0, '0, '0, '0, 1'b1);
      return;
    end
    for (int i = 0; i < 32; i++) begin
      if (!bk_valid[i]) begin
        bk_valid[i] = 1; bk_side[i] = side; bk_price[i] = price;
        bk_symbol[i] = sym; bk_ident[i] = id; bk_units[i] = qty;
        bk_arrival[i] = arrivals;
        arrivals++;
        push(lom_pkg::KIND_RESTED, id, '0, '0, '0, qty, 1'b1);
        return;
      end
    end
    push(lom_pkg::KIND_DROPPED, id, '0, '0, '0, qty, 1'b1);
  endfunction

  function void report(string what, fill_t e, fill_t a);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h actual %h", what, e, a);
  endfunction

  // compare one output item with the oldest expectation
  function void check_item(fill_t a);
    fill_t e;
    if (pending.size() == 0) begin
      report("unexpected item", '0, a);
      return;
    end
    e = pending[0];
    pending.delete(0);
    if (e.kind != a.kind) report("kind", e, a);
    if (e.incoming_id != a.incoming_id) report("incoming_id", e, a);
    if (e.resting_id != a.resting_id) report("resting_id", e, a);
    if (e.trade_price != a.trade_price) report("trade_price", e, a);
    if (e.trade_quantity != a.trade_quantity) report("trade_quantity", e, a);
    if (e.remaining_quantity != a.remaining_quantity) report("remaining_quantity", e, a);
    if (e.resting_count != a.resting_count) report("resting_count", e, a);
    if (e.last != a.last) report("last", e, a);
  endfunction
endclass

module tb_limit_order_matcher;
  import lom_pkg::*;

  logic                    clk = 0;
  logic                    rst = 1;
  logic                    s_axis_tvalid = 0;
  logic                    s_axis_tready;
  logic [IN_BYTES*8-1:0]   s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 0;
  logic [OUT_BYTES*8-1:0]  m_axis_tdata;
  logic [2:0]              m_axis_tuser;
  logic                    m_axis_tlast;

  book_scoreboard book = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_off = 0;
  int  hold_req = 0;
  int  hold_seen = 0;
  int  cycles = 0;

  // two symbols keep most levels tradable, rare random symbols force level skips
  bit [15:0] symbols[2] = '{16'h0007, 16'hffff};

  limit_order_matcher u_dut (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // watchdog on a cycle counter
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 4000000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receive side: sample at the rising edge, change tready at the falling edge
  always @(posedge clk) begin
    fill_t a;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      a.kind = m_axis_tuser;
      a.incoming_id = m_axis_tdata[31:0];
      a.resting_id = m_axis_tdata[63:32];
      a.trade_price = m_axis_tdata[79:64];
      a.trade_quantity = m_axis_tdata[103:80];
      a.remaining_quantity = m_axis_tdata[127:104];
      a.resting_count = m_axis_tdata[133:128];
      a.last = m_axis_tlast;
      book.check_item(a);
    end
  end

  // long hold-off starts when requested and is counted down here
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_off <= 1500;
      m_axis_tready <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // offer one order and wait until it is taken; called at a falling edge
  task automatic send_order(bit side, bit [15:0] price, bit [23:0] qty,
                            bit [15:0] sym, bit [31:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tdata <= {7'd0, id, sym, qty, price, side};
    s_axis_tvalid <= 1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    book.note_order(side, price, qty, sym, id);
    @(negedge clk);
  endtask

  // mostly small prices and quantities near each other so orders cross
  task automatic send_random();
    bit [15:0] p;
    bit [23:0] q;
    bit [15:0] s;
    p = ($urandom_range(9) == 0) ? 16'($urandom) : 16'(100 + $urandom_range(8));
    q = ($urandom_range(19) == 0) ? 24'($urandom) : 24'($urandom_range(1, 40));
    if ($urandom_range(29) == 0) q = 0;
    s = ($urandom_range(9) == 0) ? 16'($urandom) : symbols[$urandom_range(1)];
    send_order(1'($urandom_range(1)), p, q, s, $urandom);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (book.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: extremes, zero quantity, level skip, full fills, store full
    send_order(0, 16'hffff, 24'hffffff, 16'hffff, 32'hffffffff);
    send_order(1, 16'h0000, 24'd0, 16'h0000, 32'h0);
    send_order(1, 16'h0000, 24'd5, 16'hffff, 32'h11);
    send_order(1, 16'd10, 24'd3, 16'h0001, 32'h12);
    send_order(1, 16'd10, 24'd4, 16'hffff, 32'h13);
    send_order(0, 16'd20, 24'd2, 16'hffff, 32'h14);
    send_order(0, 16'd10, 24'd9, 16'hffff, 32'h15);
    send_order(1, 16'd50, 24'd7, 16'h0001, 32'h16);
    send_order(1, 16'd0, 24'hffffff, 16'hffff, 32'h17);
    for (int i = 0; i < 34; i++) send_order(i[0], i[0] ? 16'hfff0 : 16'd5, 24'd1,
                                            16'h0042, 32'h100 + i);
    send_order(0, 16'hffff, 24'hffffff, 16'h0042, 32'haaaaaaaa);
    send_order(1, 16'h0, 24'hffffff, 16'hffff, 32'h55555555);
    drain();
    // random phases with different idling
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 9 : 76) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 9 : 76) : 0;
      if (ph == 0) hold_req = hold_req + 1;
      for (int n = 0; n < 30; n++) send_random();
    end
    drain();
    if (book.mismatches == 0 && book.pending.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule

/* files.f */
rtl/core/lom_pkg.sv
rtl/core/limit_order_matcher.sv
tb/sv/tb_limit_order_matcher.sv
